FILE: sv/eust_pkg.sv
//------------------------------------------------------------------------------
// eust_pkg
// Shared constants, command and status types, and calendar helpers for the
// central European summer time adjuster.
//------------------------------------------------------------------------------
`default_nettype none

package eust_pkg;

	localparam int unsigned SecsW = 32;
	localparam int unsigned RemW  = 17;
	localparam int unsigned DaysW = 16;
	localparam int unsigned YearW = 12;
	localparam int unsigned NowW  = 10;

	localparam logic [RemW-1:0]  SecPerDay   = 17'd86400;
	localparam logic [RemW-1:0]  SecPerHour  = 17'd3600;
	localparam logic [SecsW-1:0] SummerShift = 32'd3600;

	// Day split: 86400 = 128 * 675. The seconds shifted right by DayShift are
	// divided by 675 through a multiply by ceil(2^35 / 675); the error term
	// times the largest shifted value stays below 2^35, so the quotient is exact.
	localparam int unsigned      DayShift   = 7;
	localparam int unsigned      RecipW     = 26;
	localparam int unsigned      RecipShift = 35;
	localparam int unsigned      ProdW      = SecsW - DayShift + RecipW;
	localparam logic [RecipW-1:0] RecipDay  = 26'd50903317;

	// Calendar state at the epoch: year 1970, 1970 mod 4 = 2, 5*1970 mod 28 = 22.
	localparam logic [YearW-1:0] EpochYear  = 12'd1970;
	localparam logic [1:0]       EpochMod4  = 2'd2;
	localparam logic [4:0]       EpochR28   = 5'd22;
	localparam logic [YearW-1:0] NoLeapYear = 12'd2100;

	localparam logic DivLastStep = 1'b1;

	// Zero-based month indexes.
	localparam logic [3:0] MonFeb = 4'd1;
	localparam logic [3:0] MonMar = 4'd2;
	localparam logic [3:0] MonApr = 4'd3;
	localparam logic [3:0] MonSep = 4'd8;
	localparam logic [3:0] MonOct = 4'd9;
	localparam logic [3:0] MonNov = 4'd10;

	typedef struct packed {
		logic load;
		logic div_step;
		logic walk_step;
		logic month_step;
		logic emit;
	} eust_cmd_t;

	typedef struct packed {
		logic div_last;
		logic walk_done;
		logic month_done;
	} eust_sts_t;

	// Length of a month given its zero-based index and the leap flag.
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: sv/eust_ctrl.sv
//------------------------------------------------------------------------------
// eust_ctrl
// Sequencer for the adjuster: divide, year and hour walk, month walk, emit.
//------------------------------------------------------------------------------
`default_nettype none

module eust_ctrl import eust_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire eust_sts_t sts,
	output eust_cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_MONTH = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_MONTH;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_MONTH: begin
				if (sts.month_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			ST_EMIT: begin
				// Wait for the output register to be free.
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result written over a word not yet taken");
`endif

endmodule

`default_nettype wire

FILE: sv/eust_dp.sv
//------------------------------------------------------------------------------
// eust_dp
// Datapath: split into days and second of day, year and hour walk,
// month walk, summer time decision and output register.
//------------------------------------------------------------------------------
`default_nettype none

module eust_dp import eust_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [SecsW-1:0] in_secs,
	input  wire eust_cmd_t        cmd,
	output eust_sts_t             sts,
	output logic [SecsW-1:0]      adj_secs,
	output logic                  active,
	output logic                  changed
);

	logic [SecsW-1:0] t_q;
	logic [RemW-1:0]  rem_q;
	logic             cnt_q;
	logic [DaysW-1:0] days_q;
	logic [4:0]       hour_q;
	logic [YearW-1:0] year_q;
	logic [1:0]       ymod4_q;
	logic [4:0]       r28_q;
	logic [3:0]       mon_q;
	logic             last_q;
	logic [SecsW-1:0] adj_q;
	logic             act_q;
	logic             chg_q;

	// Day split: the quotient comes from a reciprocal multiply, and then the
	// second of day from a multiply-back and subtract.
	logic [ProdW-1:0] recip_prod;
	logic [DaysW-1:0] day_quo;
	logic [SecsW-1:0] day_secs;
	logic [RemW-1:0]  rem_next;

	assign recip_prod = ProdW'(t_q[SecsW-1:DayShift]) * ProdW'(RecipDay);
	assign day_quo    = recip_prod[ProdW-1:RecipShift];
	assign day_secs   = SecsW'(days_q) * SecsW'(SecPerDay);
	assign rem_next   = RemW'(t_q - day_secs);

	// Year and hour walk.
	logic       leap;
	logic [8:0] ylen;
	logic       year_more;
	logic       hour_more;
	logic [4:0] r28_inc;

	assign leap      = (ymod4_q == 2'd0) && (year_q != NoLeapYear);
	assign ylen      = leap ? 9'd366 : 9'd365;
	assign year_more = (days_q >= DaysW'(ylen));
	assign hour_more = (rem_q >= SecPerHour);
	assign r28_inc   = (r28_q >= 5'd23) ? 5'(r28_q - 5'd23) : 5'(r28_q + 5'd5);

	// Month walk, through November at most.
	logic [4:0] mlen;
	logic       mon_more;

	assign mlen     = month_len(mon_q, leap);
	assign mon_more = (mon_q <= MonNov) && (days_q >= DaysW'(mlen));

	assign sts.div_last   = (cnt_q == DivLastStep);
	assign sts.walk_done  = !year_more && !hour_more;
	assign sts.month_done = !mon_more;

	// Decision: m = floor(5y/4) mod 7 = floor((5y mod 28) / 4).
	logic [2:0]      wd;
	logic [3:0]      wd_mar_sum;
	logic [3:0]      wd_oct_sum;
	logic [2:0]      wd_mar;
	logic [2:0]      wd_oct;
	logic [NowW-1:0] now;
	logic [NowW-1:0] thr_mar;
	logic [NowW-1:0] thr_oct;
	logic            summer;

	assign wd         = r28_q[4:2];
	assign wd_mar_sum = {1'b0, wd} + 4'd4;
	assign wd_oct_sum = {1'b0, wd} + 4'd1;
	assign wd_mar     = (wd_mar_sum >= 4'd7) ? 3'(wd_mar_sum - 4'd7) : wd_mar_sum[2:0];
	assign wd_oct     = (wd_oct_sum >= 4'd7) ? 3'(wd_oct_sum - 4'd7) : wd_oct_sum[2:0];
	assign now        = NowW'(hour_q) + NowW'(24) * (NowW'(days_q[4:0]) + NowW'(1));
	assign thr_mar    = NowW'(3) + NowW'(24) * (NowW'(31) - NowW'(wd_mar));
	assign thr_oct    = NowW'(3) + NowW'(24) * (NowW'(31) - NowW'(wd_oct));

	always_comb begin
		if (mon_q >= MonApr && mon_q <= MonSep) begin
			summer = 1'b1;
		end else if (mon_q == MonMar) begin
			summer = (now >= thr_mar);
		end else if (mon_q == MonOct) begin
			summer = (now < thr_oct);
		end else begin
			summer = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q     <= in_secs;
			rem_q   <= '0;
			cnt_q   <= 1'b0;
			hour_q  <= '0;
			year_q  <= EpochYear;
			ymod4_q <= EpochMod4;
			r28_q   <= EpochR28;
			mon_q   <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= 1'b1;
			if (sts.div_last) begin
				rem_q <= rem_next;
			end else begin
				days_q <= day_quo;
			end
		end else if (cmd.walk_step) begin
			if (year_more) begin
				days_q  <= DaysW'(days_q - DaysW'(ylen));
				year_q  <= YearW'(year_q + 12'd1);
				ymod4_q <= 2'(ymod4_q + 2'd1);
				r28_q   <= r28_inc;
			end
			if (hour_more) begin
				rem_q  <= RemW'(rem_q - SecPerHour);
				hour_q <= 5'(hour_q + 5'd1);
			end
		end else if (cmd.month_step) begin
			days_q <= DaysW'(days_q - DaysW'(mlen));
			mon_q  <= 4'(mon_q + 4'd1);
		end
		if (cmd.emit) begin
			adj_q <= summer ? SecsW'(t_q + SummerShift) : t_q;
			act_q <= summer;
			chg_q <= summer ^ last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.emit) begin
			last_q <= summer;
		end
	end

	assign adj_secs = adj_q;
	assign active   = act_q;
	assign changed  = chg_q;

`ifndef SYNTHESIS
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (hour_q <= 5'd23))
		else $error("hour out of range at emit");
	a_chg_track: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (chg_q == (act_q ^ $past(last_q))))
		else $error("change flag does not follow the kept flag");
	a_adj_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (adj_q == (act_q ? SecsW'($past(t_q) + SummerShift) : $past(t_q))))
		else $error("adjusted seconds disagree with the summer flag");
`endif

endmodule

`default_nettype wire

FILE: sv/eu_summer_time_adjust.sv
//------------------------------------------------------------------------------
// eu_summer_time_adjust
// Central European summer time check and one-hour adjustment of a 32-bit
// Unix seconds timestamp.
//------------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: unix_seconds
// m_*       out        m_tvalid/m_tready  m_tdata: adjusted_seconds,
//                                         m_tuser: summer_active, summer_changed
//
// One word is processed at a time. After acceptance the timestamp is split
// into day count and second of day (a reciprocal multiply, then a
// multiply-back and subtract). The year and the hour are then walked in
// parallel, one step per cycle (up to 136 years), then the month (up to 11
// steps); each walk ends with a check that it is done, and then the output
// register is written. The next word is taken when the sequencer is back in
// idle after that write; the year walk sets the longest processing time.
// Reset clears the sequencer, the output valid flag and the kept summer flag
// (winter time). The output register holds a finished word while the sink
// stalls, and the sequencer waits before writing it again; the next input word
// is taken as soon as the sequencer is idle.
//
`default_nettype none

module eu_summer_time_adjust import eust_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] unix_seconds
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] adjusted_seconds
	output logic [1:0]       m_tuser    // [0] summer_active, [1] summer_changed
);

	eust_cmd_t cmd;
	eust_sts_t sts;
	logic      active;
	logic      changed;

	// The sequencer owns the handshakes; the datapath owns all payload.
	eust_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	eust_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_secs  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.adj_secs (m_tdata),
		.active   (active),
		.changed  (changed)
	);

	// Flags travel on the user sideband, lowest bit first.
	assign m_tuser = {changed, active};

endmodule

`default_nettype wire

FILE: sim/eu_summer_time_adjust_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// eu_summer_time_adjust_tb
// Self-checking testbench for the central European summer time adjuster. A
// short table of hand-picked timestamps comes first. Random timestamps follow,
// many of them close to the spring and autumn switch weekends. Every result
// word is checked against a hand-written result (first three rows) or an
// in-bench calendar predictor, while both stream sides idle and stall at random.
//------------------------------------------------------------------------------

module eu_summer_time_adjust_tb;

	localparam int unsigned DaySecs     = 86400;
	localparam int unsigned HourSecs    = 3600;
	localparam int unsigned FirstYear   = 1970;
	localparam int unsigned LastYear    = 2105;
	localparam int unsigned RandomWords = 1950;
	localparam int unsigned DrainCycles = 250;
	localparam int unsigned CycleLimit  = 2_500_000;
	localparam int unsigned MaxReports  = 10;

	// Month numbers, counted from one.
	localparam int unsigned Feb = 2;
	localparam int unsigned Mar = 3;
	localparam int unsigned Apr = 4;
	localparam int unsigned Jun = 6;
	localparam int unsigned Sep = 9;
	localparam int unsigned Oct = 10;
	localparam int unsigned Nov = 11;
	localparam int unsigned Dec = 12;

	// One result word as the block should produce it.
	typedef struct packed {
		logic [31:0] adj;
		logic        active;
		logic        changed;
	} stamp_result_t;

	// One row of the directed table. When known is set, the result is
	// written out by hand; otherwise the predictor supplies it.
	typedef struct packed {
		logic [31:0]   stamp;
		logic          known;
		stamp_result_t result;
	} stamp_row_t;

	localparam int unsigned DirectedWords = 22;

	// The first three rows run straight after reset, so their results can be
	// read off directly. A summer stamp first shows the flag change against
	// the winter state left by reset.
	stamp_row_t directed_rows [0:DirectedWords-1] = '{
		'{32'd1593561600, 1'b1, '{32'd1593565200, 1'b1, 1'b1}}, // 2020-07-01 00:00
		'{32'd0,          1'b1, '{32'd0,          1'b0, 1'b1}}, // the epoch itself
		'{32'hFFFFFFFF,   1'b1, '{32'hFFFFFFFF,   1'b0, 1'b0}}, // last second, 2106
		'{32'd31535999,   1'b0, '0},                            // end of 1970
		'{32'd1582977600, 1'b0, '0},                            // leap day 2020
		'{32'd1616900399, 1'b0, '0},                            // spring switch, before
		'{32'd1616900400, 1'b0, '0},                            // spring switch, at
		'{32'd1617235199, 1'b0, '0},                            // last second of March
		'{32'd1633046399, 1'b0, '0},                            // last second of Sept.
		'{32'd1633046400, 1'b0, '0},                            // first second of Oct.
		'{32'd1635649199, 1'b0, '0},                            // autumn switch, before
		'{32'd1635649200, 1'b0, '0},                            // autumn switch, at
		'{32'd1635724800, 1'b0, '0},                            // first second of Nov.
		'{32'd4107542400, 1'b0, '0},                            // 2100-03-01, no leap day
		'{32'd4110177600, 1'b0, '0},                            // 2100-03-31 noon
		'{32'd4275849600, 1'b0, '0},                            // summer 2105
		'{32'd4286399400, 1'b0, '0},                            // autumn switch 2105
		'{32'd2147483647, 1'b0, '0},                            // top of signed range
		'{32'd2147483648, 1'b0, '0},
		'{32'hAAAAAAAA,   1'b0, '0},
		'{32'h55555555,   1'b0, '0},
		'{32'd4294963695, 1'b0, '0}                             // one hour below the top
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;     // [31:0] unix_seconds
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [31:0] adjusted_seconds
	logic [1:0]  m_tuser;           // [0] summer_active, [1] summer_changed

	// Predictor state: the summer flag of the last accepted word.
	logic kept_summer = 1'b0;

	stamp_result_t pending_stamps [$];

	int unsigned error_count     = 0;
	int unsigned words_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned summer_results  = 0;
	int unsigned flag_changes    = 0;
	int unsigned switch_words    = 0;
	int unsigned cycle_count     = 0;
	int unsigned sink_stall      = 0;
	bit          sender_calm     = 1'b0;
	bit          sink_calm       = 1'b0;

	eu_summer_time_adjust i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	//--------------------------------------------------------------------------
	// Calendar arithmetic
	//--------------------------------------------------------------------------

	function automatic bit leap_year(input int unsigned year);
		return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
	endfunction

	function automatic int unsigned year_days(input int unsigned year);
		return leap_year(year) ? 366 : 365;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned month,
	                                              input int unsigned year);
		int unsigned len;
		case (month)
			Feb:               len = leap_year(year) ? 29 : 28;
			Apr, Jun, Sep, Nov: len = 30;
			default:           len = 31;
		endcase
		return len;
	endfunction

	// Seconds since the epoch for a UTC calendar date; may exceed 32 bits.
	function automatic longint unsigned stamp_of(input int unsigned year,
	                                             input int unsigned month,
	                                             input int unsigned mday,
	                                             input int unsigned hour,
	                                             input int unsigned secs);
		longint unsigned day_total;
		day_total = 0;
		for (int unsigned y = FirstYear; y < year; y++)
			day_total += year_days(y);
		for (int unsigned m = 1; m < month; m++)
			day_total += days_in_month(m, year);
		day_total += mday - 1;
		return day_total * DaySecs + hour * HourSecs + secs;
	endfunction

	// Summer time decision. The year is walked from the epoch, then the
	// month, and the March and October cases compare the hour of the month
	// against the switch hour of that year's last Sunday.
	function automatic bit cest_in_effect(input logic [31:0] stamp);
		int unsigned days_left;
		int unsigned hour_of_day;
		int unsigned year;
		int unsigned month;
		int unsigned hour_count;
		days_left   = stamp / DaySecs;
		hour_of_day = (stamp % DaySecs) / HourSecs;
		year        = FirstYear;
		while (days_left >= year_days(year)) begin
			days_left -= year_days(year);
			year++;
		end
		month = 1;
		while (month < Dec && days_left >= days_in_month(month, year)) begin
			days_left -= days_in_month(month, year);
			month++;
		end
		hour_count = hour_of_day + 24 * (days_left + 1);
		if (month < Mar || month > Oct)
			return 1'b0;
		if (month > Mar && month < Oct)
			return 1'b1;
		if (month == Mar)
			return hour_count >= 3 + 24 * (31 - (5 * year / 4 + 4) % 7);
		return hour_count < 3 + 24 * (31 - (5 * year / 4 + 1) % 7);
	endfunction

	// Works out the result word for one accepted stamp and moves the kept
	// summer flag on.
	function automatic stamp_result_t predict_stamp(input logic [31:0] stamp);
		stamp_result_t res;
		res.active  = cest_in_effect(stamp);
		res.changed = res.active != kept_summer;
		res.adj     = res.active ? stamp + HourSecs : stamp;
		kept_summer = res.active;
		return res;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
	                               input logic [31:0] got);
		if (error_count < MaxReports)
			$display("mismatch at %0t ns: %s expected %h, got %h", $time, what, want, got);
		error_count++;
	endtask

	//--------------------------------------------------------------------------
	// Sender
	//--------------------------------------------------------------------------

	// Presents one stamp and waits for its handshake. The valid line is
	// only lowered when a gap is taken, so back-to-back words keep it high.
	task automatic push_word(input logic [31:0] stamp, input bit known,
	                         input stamp_result_t known_result);
		int unsigned gap;
		stamp_result_t predicted;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= stamp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_stamp(stamp);
		pending_stamps.push_back(known ? known_result : predicted);
		words_sent++;
	endtask

	// Holds the sender off until every pending result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0]     stamp;
		logic [31:0]     prev_stamp;
		longint unsigned wide_stamp;
		int unsigned     pick;
		int unsigned     month;

		prev_stamp = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < DirectedWords; i++)
			push_word(directed_rows[i].stamp, directed_rows[i].known,
			          directed_rows[i].result);
		wait_drained();

		for (int unsigned n = 0; n < RandomWords; n++) begin
			if ($urandom_range(0, 99) == 0)
				sender_calm = !sender_calm;
			if (n == RandomWords / 2)
				wait_drained();
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				stamp = $urandom;
			end else if (pick <= 7) begin
				// Last week of March or October, any hour: the switch weekend
				// always falls in it.
				month = $urandom_range(0, 1) ? Oct : Mar;
				wide_stamp = stamp_of($urandom_range(FirstYear, LastYear), month,
				                      $urandom_range(22, 31), $urandom_range(0, 23),
				                      $urandom_range(0, HourSecs - 1));
				stamp = wide_stamp[31:0];
				switch_words++;
			end else if (pick == 8) begin
				// First or last day of a random month, at the edges of the day.
				month = $urandom_range(1, 12);
				wide_stamp = stamp_of($urandom_range(FirstYear, LastYear), month, 1,
				                      0, 0);
				if ($urandom_range(0, 1))
					wide_stamp = wide_stamp - 1 - $urandom_range(0, 59);
				else
					wide_stamp = wide_stamp + $urandom_range(0, 59);
				stamp = (wide_stamp > 64'hFFFFFFFF) ? $urandom : wide_stamp[31:0];
			end else begin
				// A little after the previous stamp, so runs of one flag occur.
				stamp = prev_stamp + $urandom_range(0, 7200);
			end
			push_word(stamp, 1'b0, '0);
			prev_stamp = stamp;
		end

		s_tvalid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d words, %0d of them near the switch weekends; %0d results checked",
		         words_sent, switch_words, results_checked);
		$display("%0d results in summer time, %0d flag changes, %0d mismatches",
		         summer_results, flag_changes, error_count);
		if (error_count == 0)
			$display("eu_summer_time_adjust_tb: done, clean");
		else
			$display("eu_summer_time_adjust_tb: done, errors");
		$finish;
	end

	//--------------------------------------------------------------------------
	// Receiver: random back-pressure and the result check
	//--------------------------------------------------------------------------

	always @(posedge clk) begin
		stamp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_stamps.size() == 0) begin
				report_mismatch("unrequested result word", '0, m_tdata);
			end else begin
				want = pending_stamps.pop_front();
				if (m_tdata !== want.adj)
					report_mismatch("adjusted_seconds", want.adj, m_tdata);
				if (m_tuser[0] !== want.active)
					report_mismatch("summer_active", want.active, m_tuser[0]);
				if (m_tuser[1] !== want.changed)
					report_mismatch("summer_changed", want.changed, m_tuser[1]);
			end
			results_checked++;
			if (m_tuser[0] === 1'b1)
				summer_results++;
			if (m_tuser[1] === 1'b1)
				flag_changes++;
		end

		if (sink_stall > 0) begin
			m_tready   <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			m_tready   <= 1'b1;
			sink_stall <= pick_gap(sink_calm);
		end
		if ($urandom_range(0, 299) == 0)
			sink_calm <= !sink_calm;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still pending", cycle_count,
		         pending_stamps.size());
		$display("eu_summer_time_adjust_tb: done, errors");
		$finish;
	end

endmodule

FILE: eu_summer_time_adjust.f
sv/eust_pkg.sv
sv/eust_ctrl.sv
sv/eust_dp.sv
sv/eu_summer_time_adjust.sv
sim/eu_summer_time_adjust_tb.sv
